/* sv/tpmq_pkg.sv */
`timescale 1ns / 1ps

package tpmq_pkg;

    // Default ring sizes; each ring holds one entry fewer than its slot count
    localparam int HIGH_SLOTS_DEF = 3;
    localparam int LOW_SLOTS_DEF  = 4;

    localparam int ID_W       = 8;
    localparam int CFG_INDEX_W = 2;

    // Command codes carried on s_tuser
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PRIO_THRESH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_LIMIT    = 2'd1;

    localparam logic [ID_W-1:0] PRIO_THRESH_RST = 8'd127;
    localparam logic [ID_W-1:0] ID_LIMIT_RST    = 8'd255;

    // Ring status toward the queue controller
    typedef struct packed {
        logic empty;        // ring empty before this operation
        logic full;         // ring full before this operation
        logic empty_after;  // ring empty once this cycle's push or pop lands
    } ring_stat_t;

endpackage

/* sv/tpmq_ring.sv */
`timescale 1ns / 1ps

module tpmq_ring #(
    parameter int SLOTS = tpmq_pkg::HIGH_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        pop,
    input  logic [tpmq_pkg::ID_W-1:0]   wdata,
    output logic [tpmq_pkg::ID_W-1:0]   rdata,
    output tpmq_pkg::ring_stat_t        stat
);

    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(SLOTS - 1);

    logic [tpmq_pkg::ID_W-1:0] mem [SLOTS];
    logic [tpmq_pkg::ID_W-1:0] rdata_reg;
    logic [PTR_W-1:0]          wptr_reg;
    logic [PTR_W-1:0]          wptr_next;
    logic [PTR_W-1:0]          rptr_reg;
    logic [PTR_W-1:0]          rptr_next;
    logic [PTR_W-1:0]          wptr_inc;
    logic [PTR_W-1:0]          rptr_inc;

    assign wptr_inc = (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc = (rptr_reg == LAST) ? '0 : rptr_reg + 1'b1;

    assign wptr_next = push ? wptr_inc : wptr_reg;
    assign rptr_next = pop  ? rptr_inc : rptr_reg;

    assign stat.empty       = (wptr_reg == rptr_reg);
    assign stat.full        = (wptr_inc == rptr_reg);
    assign stat.empty_after = (wptr_next == rptr_next);

    assign rdata = rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    // Keep the head slot registered; forward a write that lands on the new head
    always_ff @(posedge clk)
    begin
        if (push && (wptr_reg == rptr_next))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[rptr_next];
        end
    end

endmodule

/* sv/two_level_priority_message_queue.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Contents
// -------   ---------  -----------------------------------  ------------------------------
// s_*       in         s_tvalid s_tready s_tdata s_tuser    command and message id
// m_*       out        m_tvalid m_tready m_tdata m_tuser    one result item per command
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// Every command gives exactly one result item; it passes the input register
// and then the result register. One command is taken every cycle while
// the output side keeps up; the single ring update per command in the
// controller stage sets that rate.
// A stalled m_tready holds the result register and backs up into s_tready.
// Reset empties both rings and restores the threshold to 127, the limit to 255.

module two_level_priority_message_queue #(
    parameter int HIGH_SLOTS = tpmq_pkg::HIGH_SLOTS_DEF,
    parameter int LOW_SLOTS  = tpmq_pkg::LOW_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] msg_id
    input  logic [0:0]                          s_tuser,   // [0] command

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] msg_out
    output logic [2:0]                          m_tuser,   // [0] msg_valid [1] accepted
                                                           // [2] all_empty

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpmq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                          cfg_data
);

    // Configuration registers
    logic [tpmq_pkg::ID_W-1:0] thresh_reg;
    logic [tpmq_pkg::ID_W-1:0] limit_reg;

    // Input register
    logic                      in_vld_reg;
    logic                      in_cmd_reg;
    logic [tpmq_pkg::ID_W-1:0] in_id_reg;

    // Result register
    logic                      out_vld_reg;
    logic [tpmq_pkg::ID_W-1:0] out_msg_reg;
    logic                      out_msg_vld_reg;
    logic                      out_acc_reg;
    logic                      out_empty_reg;

    logic                      out_vld_next;
    logic                      in_vld_next;

    logic                      advance;
    logic                      fire;
    logic                      is_enq;
    logic                      id_ok;
    logic                      to_high;
    logic                      high_push;
    logic                      low_push;
    logic                      high_pop;
    logic                      low_pop;
    logic [tpmq_pkg::ID_W-1:0] high_rdata;
    logic [tpmq_pkg::ID_W-1:0] low_rdata;
    logic [tpmq_pkg::ID_W-1:0] msg_sel;

    tpmq_pkg::ring_stat_t      high_stat;
    tpmq_pkg::ring_stat_t      low_stat;

    // Configuration is always taken; indexes past the register list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= tpmq_pkg::PRIO_THRESH_RST;
            limit_reg  <= tpmq_pkg::ID_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpmq_pkg::REG_PRIO_THRESH: thresh_reg <= cfg_data;
                tpmq_pkg::REG_ID_LIMIT:    limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the controller stage whenever the result register is free or draining
    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = in_vld_reg ? (out_vld_reg && !m_tready) || fire
                                     : (out_vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= s_tuser[0];
            in_id_reg  <= s_tdata;
        end
    end

    // Enqueue: reject ids at or above the limit, steer by threshold, drop when full
    assign is_enq  = (in_cmd_reg == tpmq_pkg::CMD_ENQ);
    assign id_ok   = (in_id_reg < limit_reg);
    assign to_high = (in_id_reg > thresh_reg);

    assign high_push = fire && is_enq && id_ok && to_high  && !high_stat.full;
    assign low_push  = fire && is_enq && id_ok && !to_high && !low_stat.full;

    // Dequeue: high ring first, then low ring
    assign high_pop = fire && !is_enq && !high_stat.empty;
    assign low_pop  = fire && !is_enq && high_stat.empty && !low_stat.empty;

    assign msg_sel = high_pop ? high_rdata :
                     low_pop  ? low_rdata  : limit_reg;

    tpmq_ring #(
        .SLOTS (HIGH_SLOTS)
    ) u_high_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (high_push),
        .pop   (high_pop),
        .wdata (in_id_reg),
        .rdata (high_rdata),
        .stat  (high_stat)
    );

    tpmq_ring #(
        .SLOTS (LOW_SLOTS)
    ) u_low_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (low_push),
        .pop   (low_pop),
        .wdata (in_id_reg),
        .rdata (low_rdata),
        .stat  (low_stat)
    );

    // Load the result register when the controller stage fires
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_msg_reg     <= msg_sel;
            out_msg_vld_reg <= high_pop || low_pop;
            out_acc_reg     <= high_push || low_push;
            out_empty_reg   <= high_stat.empty_after && low_stat.empty_after;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_msg_reg;
    assign m_tuser  = {out_empty_reg, out_acc_reg, out_msg_vld_reg};

endmodule
